// ----- hw/rtl/cau_pkg.sv -----
// Shared types, constants and saturation helper for the complex arithmetic unit.
package cau_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned XW             = 32;  // operand and result part width
  localparam int unsigned PW             = 64;  // exact product magnitude width
  localparam int unsigned QB             = 32;  // quotient bits produced
  localparam int unsigned RB             = 32;  // square root bits produced
  localparam int unsigned SV_W           = 66;  // width seen by the saturator

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_MAG  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  typedef struct packed {
    logic [XW-1:0] val;
    logic          sat;
  } sat_t;

  typedef struct packed {
    op_e  op;
    sat_t rr;
    sat_t ri;
    logic dz;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
  } side_t;

  function automatic sat_t saturate(input logic signed [SV_W-1:0] v, input int unsigned sw);
    logic signed [SV_W-1:0] hi;
    logic signed [SV_W-1:0] lo;
    sat_t r;
    hi = $signed((SV_W'(1) << (sw - 1)) - SV_W'(1));
    lo = ~hi;
    if (v > hi) begin
      r.val = hi[XW-1:0];
      r.sat = 1'b1;
    end else if (v < lo) begin
      r.val = lo[XW-1:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[XW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/complex_arithmetic_unit.sv -----
// Complex-number ALU top level: add, subtract, multiply, divide, conjugate, magnitude.
// Fully pipelined, one item per cycle while the output is not stalled. From input
// acceptance to a valid result an item passes four front stages (products, sums,
// scaling, divider set-up), 32 stages shared in parallel by the divider and the square
// root (one result bit each per stage) and an output register. The pipe advances
// whenever the output register is free or being read, or the last stage holds a
// bubble, so in_ready_o may drop only while a result waits and the last stage holds
// an item. Operands and results are signed Q16.16 by default.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           operation_i,
  input  logic signed [XW-1:0] a_re_i,
  input  logic signed [XW-1:0] a_im_i,
  input  logic signed [XW-1:0] b_re_i,
  input  logic signed [XW-1:0] b_im_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [XW-1:0] res_re_o,
  output logic signed [XW-1:0] res_im_o,
  output logic [1:0]           status_o
);

  localparam int unsigned SAT_W = (DATA_WIDTH > XW) ? XW : DATA_WIDTH;
  localparam int unsigned NW    = PW + FRAC_BITS;
  localparam int unsigned LAT   = 4 + QB;

  logic          en, out_load;
  logic [LAT-1:0] vld_q;
  logic          out_valid_q;
  logic [NW-1:0] n_re, n_im;
  logic [PW-1:0] den, sqs;
  side_t         side_f;
  side_t         side_q [QB];
  side_t         tail;
  logic [QB-1:0] q_re, q_im;
  logic [RB-1:0] root;
  sat_t          rr_d, ri_d;
  status_e       st_d;

  assign out_load   = out_ready_i || !out_valid_q;
  assign en         = out_load || !vld_q[LAT-1];
  assign in_ready_o = en;

  cau_front #(
    .FRAC_BITS(FRAC_BITS),
    .SAT_W    (SAT_W)
  ) u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .op_i  (op_e'(operation_i)),
    .a_re_i(a_re_i),
    .a_im_i(a_im_i),
    .b_re_i(b_re_i),
    .b_im_i(b_im_i),
    .n_re_o(n_re),
    .n_im_o(n_im),
    .den_o (den),
    .sqs_o (sqs),
    .side_o(side_f)
  );

  cau_divider #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .n_re_i(n_re),
    .n_im_i(n_im),
    .den_i (den),
    .q_re_o(q_re),
    .q_im_o(q_im)
  );

  cau_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   (sqs),
    .root_o(root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_f;
      for (int k = 1; k < QB; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign tail = side_q[QB-1];

  function automatic sat_t div_lane(input logic [QB-1:0] q, input logic neg, input logic ovf,
                                    input int unsigned sw);
    logic signed [SV_W-1:0] v;
    logic signed [SV_W-1:0] big;
    big = $signed(SV_W'(1) << (QB + 1));
    if (ovf) begin
      v = neg ? -big : big;
    end else begin
      v = neg ? -$signed(SV_W'(q)) : $signed(SV_W'(q));
    end
    return saturate(v, sw);
  endfunction

  always_comb begin
    rr_d = '0;
    ri_d = '0;
    st_d = ST_OK;
    case (tail.op)
      OP_ADD, OP_SUB, OP_MUL, OP_CONJ: begin
        rr_d = tail.rr;
        ri_d = tail.ri;
        st_d = (tail.rr.sat || tail.ri.sat) ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (tail.dz) begin
          st_d = ST_DIV0;
        end else begin
          rr_d = div_lane(q_re, tail.neg_re, tail.ovf_re, SAT_W);
          ri_d = div_lane(q_im, tail.neg_im, tail.ovf_im, SAT_W);
          st_d = (rr_d.sat || ri_d.sat) ? ST_SAT : ST_OK;
        end
      end
      OP_MAG: begin
        rr_d = saturate($signed(SV_W'(root)), SAT_W);
        st_d = rr_d.sat ? ST_SAT : ST_OK;
      end
      default: begin
        rr_d = '0;
        ri_d = '0;
        st_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
      if (out_load) begin
        out_valid_q <= vld_q[LAT-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_re_o <= rr_d.val;
      res_im_o <= ri_d.val;
      status_o <= st_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/cau_front.sv -----
// Front stages: products, sums, simple results and divider operand set-up.
module cau_front import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned SAT_W     = DATA_WIDTH_DEF,
  localparam int unsigned NW       = PW + FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  op_e                  op_i,
  input  logic signed [XW-1:0] a_re_i,
  input  logic signed [XW-1:0] a_im_i,
  input  logic signed [XW-1:0] b_re_i,
  input  logic signed [XW-1:0] b_im_i,
  output logic [NW-1:0]        n_re_o,
  output logic [NW-1:0]        n_im_o,
  output logic [PW-1:0]        den_o,
  output logic [PW-1:0]        sqs_o,
  output side_t                side_o
);

  // stage 1
  logic signed [XW:0]   lre_d, lim_d;
  logic signed [XW-1:0] x0, x1;
  logic signed [PW-1:0] sq0_full, sq1_full;
  op_e                  op1_q;
  logic signed [XW:0]   lre1_q, lim1_q;
  logic signed [PW-1:0] prr1_q, pii1_q, pir1_q, pri1_q;
  logic [PW-2:0]        sq0_1_q, sq1_1_q;

  always_comb begin
    lre_d = '0;
    lim_d = '0;
    case (op_i)
      OP_ADD: begin
        lre_d = (XW+1)'(a_re_i) + (XW+1)'(b_re_i);
        lim_d = (XW+1)'(a_im_i) + (XW+1)'(b_im_i);
      end
      OP_SUB: begin
        lre_d = (XW+1)'(a_re_i) - (XW+1)'(b_re_i);
        lim_d = (XW+1)'(a_im_i) - (XW+1)'(b_im_i);
      end
      OP_CONJ: begin
        lre_d = (XW+1)'(a_re_i);
        lim_d = -(XW+1)'(a_im_i);
      end
      default: begin
        lre_d = '0;
        lim_d = '0;
      end
    endcase
  end

  assign x0       = (op_i == OP_MAG) ? a_re_i : b_re_i;
  assign x1       = (op_i == OP_MAG) ? a_im_i : b_im_i;
  assign sq0_full = PW'(x0) * PW'(x0);
  assign sq1_full = PW'(x1) * PW'(x1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q   <= op_i;
      lre1_q  <= lre_d;
      lim1_q  <= lim_d;
      prr1_q  <= PW'(a_re_i) * PW'(b_re_i);
      pii1_q  <= PW'(a_im_i) * PW'(b_im_i);
      pir1_q  <= PW'(a_im_i) * PW'(b_re_i);
      pri1_q  <= PW'(a_re_i) * PW'(b_im_i);
      sq0_1_q <= sq0_full[PW-2:0];
      sq1_1_q <= sq1_full[PW-2:0];
    end
  end

  // stage 2
  op_e                op2_q;
  sat_t               lr2_q, li2_q;
  logic signed [PW:0] cre2_q, cim2_q;
  logic [PW-1:0]      sqs2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op2_q  <= op1_q;
      lr2_q  <= saturate(SV_W'(lre1_q), SAT_W);
      li2_q  <= saturate(SV_W'(lim1_q), SAT_W);
      cre2_q <= (op1_q == OP_DIV) ? (PW+1)'(prr1_q) + (PW+1)'(pii1_q)
                                  : (PW+1)'(prr1_q) - (PW+1)'(pii1_q);
      cim2_q <= (op1_q == OP_DIV) ? (PW+1)'(pir1_q) - (PW+1)'(pri1_q)
                                  : (PW+1)'(pir1_q) + (PW+1)'(pri1_q);
      sqs2_q <= PW'(sq0_1_q) + PW'(sq1_1_q);
    end
  end

  // stage 3
  op_e           op3_q;
  sat_t          rr3_q, ri3_q;
  logic          neg_re3_q, neg_im3_q, dz3_q;
  logic [PW-1:0] mre3_q, mim3_q, sqs3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op3_q     <= op2_q;
      rr3_q     <= (op2_q == OP_MUL) ? saturate(SV_W'(cre2_q >>> FRAC_BITS), SAT_W) : lr2_q;
      ri3_q     <= (op2_q == OP_MUL) ? saturate(SV_W'(cim2_q >>> FRAC_BITS), SAT_W) : li2_q;
      neg_re3_q <= cre2_q[PW];
      neg_im3_q <= cim2_q[PW];
      mre3_q    <= cre2_q[PW] ? PW'(-cre2_q) : cre2_q[PW-1:0];
      mim3_q    <= cim2_q[PW] ? PW'(-cim2_q) : cim2_q[PW-1:0];
      sqs3_q    <= sqs2_q;
      dz3_q     <= (sqs2_q == '0);
    end
  end

  // stage 4: quotient overflow check and scaled numerators
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_re_o        <= NW'(mre3_q) << FRAC_BITS;
      n_im_o        <= NW'(mim3_q) << FRAC_BITS;
      den_o         <= sqs3_q;
      sqs_o         <= sqs3_q;
      side_o.op     <= op3_q;
      side_o.rr     <= rr3_q;
      side_o.ri     <= ri3_q;
      side_o.dz     <= dz3_q;
      side_o.neg_re <= neg_re3_q;
      side_o.neg_im <= neg_im3_q;
      side_o.ovf_re <= (mre3_q >> (QB - FRAC_BITS)) >= sqs3_q;
      side_o.ovf_im <= (mim3_q >> (QB - FRAC_BITS)) >= sqs3_q;
    end
  end

endmodule

// ----- hw/rtl/cau_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
module cau_divider import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned NW       = PW + FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] n_re_i,
  input  logic [NW-1:0] n_im_i,
  input  logic [PW-1:0] den_i,
  output logic [QB-1:0] q_re_o,
  output logic [QB-1:0] q_im_o
);

  logic [PW-1:0] rem_q [QB][2];
  logic [QB-1:0] nl_q  [QB][2];
  logic [QB-1:0] q_q   [QB][2];
  logic [PW-1:0] den_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [PW-1:0] den_in;
    assign den_in = (k == 0) ? den_i : den_q[(k == 0) ? 0 : k-1];

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [PW-1:0] rem_in;
      logic [QB-1:0] nl_in, q_in;
      logic [PW:0]   t;
      logic          ge;

      if (k == 0) begin : g_first
        logic [NW-1:0] n;
        assign n      = (l == 0) ? n_re_i : n_im_i;
        assign rem_in = PW'(n >> QB);
        assign nl_in  = n[QB-1:0];
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem_q[k-1][l];
        assign nl_in  = nl_q[k-1][l];
        assign q_in   = q_q[k-1][l];
      end

      assign t  = {rem_in, nl_in[QB-1]};
      assign ge = t >= {1'b0, den_in};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge ? PW'(t - {1'b0, den_in}) : t[PW-1:0];
          nl_q[k][l]  <= nl_in << 1;
          q_q[k][l]   <= {q_in[QB-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_in;
      end
    end
  end

  assign q_re_o = q_q[QB-1][0];
  assign q_im_o = q_q[QB-1][1];

endmodule

// ----- hw/rtl/cau_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one root bit per stage.
module cau_sqrt import cau_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [PW-1:0] v_i,
  output logic [RB-1:0] root_o
);

  logic [RB+1:0] rem_q  [RB];
  logic [RB-1:0] root_q [RB];
  logic [PW-1:0] v_q    [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [RB+1:0] rem_in;
    logic [RB-1:0] root_in;
    logic [PW-1:0] v_in;
    logic [RB+3:0] t, trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = v_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign t     = {rem_in, v_in[PW-1:PW-2]};
    assign trial = (RB+4)'({root_in, 2'b01});
    assign ge    = t >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (RB+2)'(t - trial) : t[RB+1:0];
        root_q[k] <= {root_in[RB-2:0], ge};
        v_q[k]    <= v_in << 2;
      end
    end
  end

  assign root_o = root_q[RB-1];

endmodule
